/* rtl/tdp_pkg.sv */
package tdp_pkg;

  // Default width of the tested number.
  localparam int unsigned NumberWidthDefault = 32;

  // Step counter width and program addresses.
  localparam int unsigned PcWidth = 4;

  localparam logic [PcWidth-1:0] StepWait     = 4'd0;
  localparam logic [PcWidth-1:0] StepLtTwo    = 4'd1;
  localparam logic [PcWidth-1:0] StepEqTwo    = 4'd2;
  localparam logic [PcWidth-1:0] StepEven     = 4'd3;
  localparam logic [PcWidth-1:0] StepLoop     = 4'd4;
  localparam logic [PcWidth-1:0] StepDivide   = 4'd5;
  localparam logic [PcWidth-1:0] StepRemCheck = 4'd6;
  localparam logic [PcWidth-1:0] StepBack     = 4'd7;
  localparam logic [PcWidth-1:0] StepEmit     = 4'd8;
  localparam logic [PcWidth-1:0] StepRestart  = 4'd9;

  // Jump conditions; a step jumps to its target when the condition holds,
  // otherwise it advances to the next step.
  typedef enum logic [3:0] {
    CND_ALWAYS   = 4'd0,
    CND_NO_INPUT = 4'd1,
    CND_N_LT2    = 4'd2,
    CND_N_EQ2    = 4'd3,
    CND_N_EVEN   = 4'd4,
    CND_SQ_GT_N  = 4'd5,
    CND_DIV_MORE = 4'd6,
    CND_REM_ZERO = 4'd7,
    CND_OUT_BUSY = 4'd8
  } cond_e;

  // One control word of the program.
  typedef struct packed {
    logic               ready;      // take an input item in this step
    logic               div_start;  // clear remainder, load bit counter
    logic               div_step;   // one restoring-division bit
    logic               d_adv;      // advance divisor by two, update square
    logic               flag_we;    // write the result flag
    logic               flag_val;   // value for the result flag
    logic               emit;       // hand the result to the output register
    cond_e              cond;
    logic [PcWidth-1:0] target;
  } ctrl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic n_lt2;
    logic n_eq2;
    logic n_even;
    logic sq_gt_n;
    logic div_more;
    logic rem_zero;
  } status_t;

  function automatic ctrl_t ucode(input logic [PcWidth-1:0] pc);
    ctrl_t w;
    w = '{ready: 1'b0, div_start: 1'b0, div_step: 1'b0, d_adv: 1'b0,
          flag_we: 1'b0, flag_val: 1'b0, emit: 1'b0,
          cond: CND_ALWAYS, target: StepWait};
    case (pc)
      StepWait: begin
        w.ready  = 1'b1;
        w.cond   = CND_NO_INPUT;
        w.target = StepWait;
      end
      StepLtTwo: begin
        w.flag_we = 1'b1;
        w.cond    = CND_N_LT2;
        w.target  = StepEmit;
      end
      StepEqTwo: begin
        w.flag_we  = 1'b1;
        w.flag_val = 1'b1;
        w.cond     = CND_N_EQ2;
        w.target   = StepEmit;
      end
      StepEven: begin
        w.flag_we = 1'b1;
        w.cond    = CND_N_EVEN;
        w.target  = StepEmit;
      end
      StepLoop: begin
        w.flag_we   = 1'b1;
        w.flag_val  = 1'b1;
        w.div_start = 1'b1;
        w.cond      = CND_SQ_GT_N;
        w.target    = StepEmit;
      end
      StepDivide: begin
        w.div_step = 1'b1;
        w.cond     = CND_DIV_MORE;
        w.target   = StepDivide;
      end
      StepRemCheck: begin
        w.flag_we = 1'b1;
        w.d_adv   = 1'b1;
        w.cond    = CND_REM_ZERO;
        w.target  = StepEmit;
      end
      StepBack: begin
        w.cond   = CND_ALWAYS;
        w.target = StepLoop;
      end
      StepEmit: begin
        w.emit   = 1'b1;
        w.cond   = CND_OUT_BUSY;
        w.target = StepEmit;
      end
      StepRestart: begin
        w.cond   = CND_ALWAYS;
        w.target = StepWait;
      end
      default: begin
        w.cond   = CND_ALWAYS;
        w.target = StepWait;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/tdp_sequencer.sv */
module tdp_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tdp_pkg::status_t status_i,
  output tdp_pkg::ctrl_t   ctrl_o
);

  logic [tdp_pkg::PcWidth-1:0] pc_q, pc_d;
  tdp_pkg::ctrl_t              ctrl;
  logic                        taken;

  assign ctrl   = tdp_pkg::ucode(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    case (ctrl.cond)
      tdp_pkg::CND_ALWAYS:   taken = 1'b1;
      tdp_pkg::CND_NO_INPUT: taken = !status_i.in_valid;
      tdp_pkg::CND_N_LT2:    taken = status_i.n_lt2;
      tdp_pkg::CND_N_EQ2:    taken = status_i.n_eq2;
      tdp_pkg::CND_N_EVEN:   taken = status_i.n_even;
      tdp_pkg::CND_SQ_GT_N:  taken = status_i.sq_gt_n;
      tdp_pkg::CND_DIV_MORE: taken = status_i.div_more;
      tdp_pkg::CND_REM_ZERO: taken = status_i.rem_zero;
      tdp_pkg::CND_OUT_BUSY: taken = status_i.out_busy;
      default:               taken = 1'b1;
    endcase
  end

  assign pc_d = taken ? ctrl.target : pc_q + tdp_pkg::PcWidth'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tdp_pkg::StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/tdp_datapath.sv */
module tdp_datapath #(
  parameter int unsigned NUMBER_WIDTH = tdp_pkg::NumberWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tdp_pkg::ctrl_t          ctrl_i,
  input  logic                    load_i,
  input  logic [NUMBER_WIDTH-1:0] number_i,
  output logic                    n_lt2_o,
  output logic                    n_eq2_o,
  output logic                    n_even_o,
  output logic                    sq_gt_n_o,
  output logic                    div_more_o,
  output logic                    rem_zero_o,
  output logic                    flag_o
);

  localparam int unsigned DW = NUMBER_WIDTH / 2 + 2;        // divisor bits
  localparam int unsigned SW = NUMBER_WIDTH + 1;            // square bits
  localparam int unsigned CW = $clog2(NUMBER_WIDTH + 1);    // bit counter

  logic [NUMBER_WIDTH-1:0] n_q, nsh_q;
  logic [DW-1:0]           d_q, r_q, r_d;
  logic [SW-1:0]           sq_q, sq_next;
  logic [CW-1:0]           cnt_q;
  logic                    flag_q;
  logic [DW:0]             r_sh, r_sub;
  logic                    r_ge;

  // Square of the next odd divisor: (d+2)^2 = d^2 + 4d + 4.
  assign sq_next = sq_q + (SW'(d_q) << 2) + SW'(4);

  // Restoring division, one numerator bit per cycle.
  assign r_sh  = {r_q, nsh_q[NUMBER_WIDTH-1]};
  assign r_sub = r_sh - {1'b0, d_q};
  assign r_ge  = r_sh >= {1'b0, d_q};
  assign r_d   = r_ge ? r_sub[DW-1:0] : r_sh[DW-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      n_q  <= number_i;
      d_q  <= DW'(3);
      sq_q <= SW'(9);
    end else if (ctrl_i.d_adv) begin
      d_q  <= d_q + DW'(2);
      sq_q <= sq_next;
    end
    if (ctrl_i.div_start) begin
      nsh_q <= n_q;
      r_q   <= '0;
    end else if (ctrl_i.div_step) begin
      nsh_q <= {nsh_q[NUMBER_WIDTH-2:0], 1'b0};
      r_q   <= r_d;
    end
    if (ctrl_i.flag_we) begin
      flag_q <= ctrl_i.flag_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.div_start) begin
      cnt_q <= CW'(NUMBER_WIDTH);
    end else if (ctrl_i.div_step) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  assign n_lt2_o    = n_q[NUMBER_WIDTH-1:1] == '0;
  assign n_eq2_o    = n_q == NUMBER_WIDTH'(2);
  assign n_even_o   = !n_q[0];
  assign sq_gt_n_o  = sq_q > SW'(n_q);
  assign div_more_o = cnt_q != CW'(1);
  assign rem_zero_o = r_q == '0;
  assign flag_o     = flag_q;

  a_step_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_step |-> cnt_q != '0)
    else $error("division step with no bits left");

  a_divisor_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_start |-> d_q[0])
    else $error("trial divisor is even");

  a_count_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_start |=> cnt_q == CW'(NUMBER_WIDTH))
    else $error("bit counter not reloaded at division start");

endmodule

/* rtl/trial_division_primality_test_core.sv */
// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------------
// in        | s_axis_tvalid, s_axis_tready | s_axis_tdata: number
// out       | m_axis_tvalid, m_axis_tready | m_axis_tdata: prime_flag
//
// Testing: values below 3 and even values resolve without any division. An
// odd value is divided by each odd divisor in turn until the divisor's
// square exceeds it or one divides it, up to about 2^(NUMBER_WIDTH/2 - 1)
// divisors; a single one-bit-per-cycle remainder unit does every division.
// Reset: asynchronous, active low; it returns the step counter to the wait
// step and empties the output register.
// Stalls: a result waits in the output register while the next item is
// already taken and tested; the emit step holds until that register frees.
module trial_division_primality_test_core #(
  parameter int unsigned NUMBER_WIDTH = tdp_pkg::NumberWidthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((NUMBER_WIDTH + 7) / 8)*8-1:0] s_axis_tdata,   // [W-1:0] number
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [7:0]                            m_axis_tdata    // [0] prime_flag
);

  tdp_pkg::ctrl_t   ctrl;
  tdp_pkg::status_t status;
  logic             accept;
  logic             out_free;
  logic             out_load;
  logic             flag;
  logic             out_valid_q;
  logic             out_flag_q;

  // An item transfers only in the wait step of the program.
  assign s_axis_tready = ctrl.ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The output register frees in the same cycle its result is taken.
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = ctrl.emit && out_free;

  tdp_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  tdp_datapath #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .load_i    (accept),
    .number_i  (s_axis_tdata[NUMBER_WIDTH-1:0]),
    .n_lt2_o   (status.n_lt2),
    .n_eq2_o   (status.n_eq2),
    .n_even_o  (status.n_even),
    .sq_gt_n_o (status.sq_gt_n),
    .div_more_o(status.div_more),
    .rem_zero_o(status.rem_zero),
    .flag_o    (flag)
  );

  assign status.in_valid = s_axis_tvalid;
  assign status.out_busy = !out_free;

  // Output register: hold the result until the downstream side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_flag_q <= flag;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_flag_q};

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("second item taken while one is under test");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("pending result overwritten");

  a_emit_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("emitted result not presented");

endmodule

/* tb/trial_division_primality_test_core_checker.sv */
// Watches both stream channels of the primality core. Works out the expected
// prime flag for every number that goes in, and compares each flag that comes
// out with the oldest one still owed.
module trial_division_primality_test_core_checker #(
  parameter int unsigned NUMBER_WIDTH = tdp_pkg::NumberWidthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  input  logic                                  s_axis_tready,
  input  logic [((NUMBER_WIDTH + 7) / 8)*8-1:0] s_axis_tdata,   // [W-1:0] number
  input  logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic [7:0]                            m_axis_tdata,   // [0] prime_flag
  output int unsigned                           mismatch_count_o,
  output int unsigned                           pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [NUMBER_WIDTH-1:0] number;
    logic                    prime_flag;
  } verdict_t;

  verdict_t verdicts_owed[$];
  verdict_t arrived;
  verdict_t oldest;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  // Plain trial division over odd divisors; d <= n / d keeps d*d from overflowing.
  function automatic logic prime_by_trial(input logic [NUMBER_WIDTH-1:0] number);
    logic [63:0] value;
    logic [63:0] d;
    value = 64'(number);
    if (value < 64'd2) return 1'b0;
    if (value == 64'd2) return 1'b1;
    if (!value[0]) return 1'b0;
    for (d = 64'd3; d <= value / d; d += 64'd2) begin
      if (value % d == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        arrived.number     = s_axis_tdata[NUMBER_WIDTH-1:0];
        arrived.prime_flag = prime_by_trial(s_axis_tdata[NUMBER_WIDTH-1:0]);
        verdicts_owed      = {verdicts_owed, arrived};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_owed.size() == 0) begin
          report_mismatch($sformatf("prime_flag %b with no number outstanding",
                                    m_axis_tdata[0]));
        end else begin
          oldest = verdicts_owed.pop_front();
          if (m_axis_tdata[0] !== oldest.prime_flag) begin
            report_mismatch($sformatf("number %0d: prime_flag %b, want %b",
                                      oldest.number, m_axis_tdata[0], oldest.prime_flag));
          end
        end
      end
      pending_o <= verdicts_owed.size();
    end
  end

endmodule

/* tb/trial_division_primality_test_core_test.sv */
// Drives numbers into the primality core and paces its result channel; the
// checker beside the core does all prediction and comparison.
module trial_division_primality_test_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumberWidth    = tdp_pkg::NumberWidthDefault;
  localparam int unsigned DataBits       = ((NumberWidth + 7) / 8) * 8;
  // Odd divisors a random number may need before it resolves; covers every
  // 16-bit value.
  localparam int unsigned MaxTrials      = 128;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned SettleCycles   = 60;
  localparam int unsigned TimeoutNs      = 10_000_000;
  localparam int unsigned CornerCount    = 24;

  localparam logic [31:0] CornerNumbers [0:CornerCount-1] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9,
    32'd15, 32'd25, 32'd49, 32'd97, 32'd121, 32'd169,
    32'd63001,      // square of 251
    32'd65521,      // largest 16-bit prime
    32'd65537,
    32'd65535,
    32'd196563,     // 3 * 65521
    32'h5555_5555,
    32'h8000_0000,
    32'h8000_0001,
    32'hFFFF_FFFE,
    32'hFFFF_FFFF
  };

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataBits-1:0] s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned results_pending;

  // Shared pacing controls: no random gaps near the end, and one long stall
  // of the result channel on request.
  logic calm         = 1'b0;
  logic hold_request = 1'b0;

  trial_division_primality_test_core #(
    .NUMBER_WIDTH (NumberWidth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  trial_division_primality_test_core_checker #(
    .NUMBER_WIDTH (NumberWidth)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("trial_division_primality_test_core test failed");
    $finish;
  end

  // Number of odd divisors the core tries on this value, stopping once past
  // the budget. Used only to keep random items cheap.
  function automatic int unsigned divisor_trials(input logic [31:0] number);
    logic [63:0] value;
    logic [63:0] d;
    int unsigned tries;
    value = 64'(number);
    tries = 0;
    if (value < 64'd3 || !value[0]) return 0;
    for (d = 64'd3; d <= value / d; d += 64'd2) begin
      tries++;
      if (value % d == 64'd0 || tries > MaxTrials) return tries;
    end
    return tries;
  endfunction

  // Mostly small values; full-width values are either even or odd with a
  // small factor, so every bit toggles without paying for a large prime.
  function automatic logic [31:0] draw_number();
    logic [31:0] number;
    int unsigned pick;
    do begin
      pick = $urandom_range(0, 99);
      if (pick < 35) number = $urandom_range(0, 255);
      else if (pick < 60) number = $urandom_range(0, 4095);
      else if (pick < 72) number = $urandom_range(0, 65535);
      else if (pick < 82) number = $urandom() & ~32'd1;
      else number = $urandom() | 32'd1;
    end while (divisor_trials(number) > MaxTrials);
    return number;
  endfunction

  // Offer one number and hold it until the transfer; tvalid stays high on
  // return so a back-to-back item can follow without a gap.
  task automatic offer_number(input logic [31:0] number);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tdata  <= DataBits'(number);
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Wait for every outstanding flag; the first edge lets the count catch up
  // with the transfer that just happened.
  task automatic wait_results_drained();
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  // Result channel pacing: random stalls, free-running stretches, and one
  // long hold-off counted here.
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < CornerCount; i++) offer_number(CornerNumbers[i]);

    repeat (30) offer_number(draw_number());

    // Stall the result side while cheap even numbers keep coming, so the
    // output register fills and the input backs up.
    hold_request = 1'b1;
    repeat (12) offer_number($urandom() & ~32'd1);
    s_axis_tvalid <= 1'b0;
    wait_results_drained();

    repeat (15) offer_number(draw_number());
    calm = 1'b1;
    repeat (20) offer_number(draw_number());
    s_axis_tvalid <= 1'b0;

    wait_results_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("trial_division_primality_test_core test passed");
    end else begin
      $display("trial_division_primality_test_core test failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tdp_pkg.sv
rtl/tdp_sequencer.sv
rtl/tdp_datapath.sv
rtl/trial_division_primality_test_core.sv
tb/trial_division_primality_test_core_checker.sv
tb/trial_division_primality_test_core_test.sv
